FILE: rtl/minmax_pyramid_address_gen_macros.svh
// ----------------------------------------------------------------------------
// minmax_pyramid_address_gen_macros.svh
// Assertion macros shared by the pyramid address generator RTL.
// ----------------------------------------------------------------------------
`ifndef MINMAX_PYRAMID_ADDRESS_GEN_MACROS_SVH
`define MINMAX_PYRAMID_ADDRESS_GEN_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define MMPAG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define MMPAG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mmpag_pkg.sv
// ----------------------------------------------------------------------------
// mmpag_pkg
// Widths, power-of-3 table, status codes and control structs for the
// min/max pyramid address generator.
// ----------------------------------------------------------------------------
package mmpag_pkg;

    localparam int INDEX_BITS = 40;
    localparam int MAX_LEVELS = 21;

    localparam int DS_W      = 32;   // downsampling factor
    localparam int CNT_W     = 32;   // sample count, quotient, clipped columns
    localparam int ST_W      = 3;
    localparam int ADDR_W    = 36;
    localparam int COPY_W    = 33;
    localparam int OFS_W     = 40;
    localparam int WLEN_W    = 40;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam int LVL_W     = $clog2(MAX_LEVELS + 1);
    localparam int DIV_CNT_W = $clog2(DS_W + 1);

    localparam longint unsigned POW3_MAX = longint'(3) ** MAX_LEVELS;
    localparam int POW_W  = $clog2(POW3_MAX + 1);
    localparam int CMP_W  = (POW_W > DS_W) ? POW_W : DS_W;
    localparam int OFF_W  = POW_W + 1;
    localparam int AW     = ((INDEX_BITS > WLEN_W) ? INDEX_BITS : WLEN_W) + 2;
    localparam int SUM_W  = ((OFF_W > ADDR_W) ? OFF_W : ADDR_W) + 2;

    typedef logic [POW_W-1:0] pow3_t;
    typedef pow3_t pow3_tab_t [0:MAX_LEVELS];

    function automatic pow3_tab_t pow3_table();
        pow3_tab_t t;
        longint unsigned p;
        p = 1;
        for (int i = 0; i <= MAX_LEVELS; i++) begin
            t[i] = pow3_t'(p);
            p = p * 3;
        end
        return t;
    endfunction

    localparam pow3_tab_t POW3 = pow3_table();

    typedef enum logic [ST_W-1:0] {
        ST_SERVED       = 3'd0,
        ST_NOT_READY    = 3'd1,
        ST_OUT_OF_RANGE = 3'd2,
        ST_BAD_FACTOR   = 3'd3,
        ST_BAD_RANGE    = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PYRAMID_READY = 1'b0,
        REG_SAMPLE_COUNT  = 1'b1
    } cfg_reg_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item, start divider and level scan
        logic div_step;  // one divider bit + one level scan step
        logic range;     // clip window against available columns
        logic acc_step;  // add one pyramid level to the offset
        logic out_load;  // move the result into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic early;     // not ready, bad range or zero factor
        logic div_done;  // quotient and level scan finished
        logic acc_done;  // offset complete (or nothing to add)
    } sts_t;

endpackage

FILE: rtl/mmpag_ctrl.sv
// ----------------------------------------------------------------------------
// mmpag_ctrl
// Sequencer: accept, divide/scan, clip, accumulate, hand off result.
// ----------------------------------------------------------------------------
module mmpag_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output mmpag_pkg::cmd_t    cmd,
    input  mmpag_pkg::sts_t    sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_RANGE,
        S_ACC,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                state_next = sts.early ? S_DONE : S_DIV;
            end
            S_DIV: begin
                if (sts.div_done) begin
                    state_next = S_RANGE;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_RANGE: begin
                cmd.range  = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                if (sts.acc_done) begin
                    state_next = S_DONE;
                end else begin
                    cmd.acc_step = 1'b1;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // output slot: set on load, cleared when the transfer completes
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/mmpag_dpath.sv
// ----------------------------------------------------------------------------
// mmpag_dpath
// Input capture, restoring divider, power-of-3 level scan, window clipping,
// level offset accumulator and result register.
// ----------------------------------------------------------------------------
module mmpag_dpath (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  mmpag_pkg::cmd_t                          cmd,
    output mmpag_pkg::sts_t                          sts,
    input  logic                                     cfg_pyramid_ready,
    input  logic [mmpag_pkg::CNT_W-1:0]              cfg_sample_count,
    input  logic signed [mmpag_pkg::INDEX_BITS-1:0]  s_first_index,
    input  logic signed [mmpag_pkg::INDEX_BITS-1:0]  s_last_index,
    input  logic [mmpag_pkg::DS_W-1:0]               s_decim_factor,
    output logic [mmpag_pkg::ST_W-1:0]               m_status,
    output logic                                     m_from_pyramid,
    output logic [mmpag_pkg::ADDR_W-1:0]             m_min_start,
    output logic [mmpag_pkg::ADDR_W-1:0]             m_max_start,
    output logic [mmpag_pkg::COPY_W-1:0]             m_copy_count,
    output logic [mmpag_pkg::OFS_W-1:0]              m_dest_offset,
    output logic [mmpag_pkg::WLEN_W-1:0]             m_window_length
);

    localparam int IB = mmpag_pkg::INDEX_BITS;
    localparam int AW = mmpag_pkg::AW;
    localparam int DW = mmpag_pkg::DS_W;
    localparam int CW = mmpag_pkg::CNT_W;
    localparam int LW = mmpag_pkg::LVL_W;

    // ---------------- captured item ----------------
    logic signed [IB-1:0] t1_reg, t2_reg;
    logic [DW-1:0]        ds_reg;
    logic                 nr_reg, br_reg, zf_reg, raw_reg;
    logic [mmpag_pkg::WLEN_W-1:0] wlen_reg;

    logic signed [AW-1:0] w_full;
    logic [mmpag_pkg::WLEN_W-1:0] wlen_c;

    assign w_full = AW'(s_last_index) - AW'(s_first_index) + AW'(1);
    assign wlen_c = (w_full[AW-1:mmpag_pkg::WLEN_W] != '0) ? '1
                                                             : w_full[mmpag_pkg::WLEN_W-1:0];

    // ---------------- divider: sample_count / ds ----------------
    logic [DW-1:0]                     rem_reg, quo_reg;
    logic [mmpag_pkg::DIV_CNT_W-1:0]   div_cnt_reg;
    logic [DW+1:0]                     div_trial;

    assign div_trial = {1'b0, rem_reg, quo_reg[DW-1]} - {2'b00, ds_reg};

    // ---------------- level scan ----------------
    logic [LW-1:0]                 li_reg, lvl_a_reg, lvl_k_reg;
    logic                          scan_done_reg, a_found_reg, pot_reg;
    logic [mmpag_pkg::CMP_W-1:0]   p_cmp, n_cmp, d_cmp;
    logic                          li_at_max;

    assign p_cmp     = mmpag_pkg::CMP_W'(mmpag_pkg::POW3[li_reg]);
    assign n_cmp     = mmpag_pkg::CMP_W'(cfg_sample_count);
    assign d_cmp     = mmpag_pkg::CMP_W'(ds_reg);
    assign li_at_max = (li_reg == LW'(mmpag_pkg::MAX_LEVELS));

    // ---------------- window clipping ----------------
    logic signed [AW-1:0] t1_s, t2_s, av_s, neg_t1;
    logic                 oor_c, oor_reg;
    logic [CW-1:0]        s1_c, s2_c, s1_reg, s2_reg;
    logic [mmpag_pkg::OFS_W-1:0] dst_c, dst_reg;

    assign t1_s   = AW'(t1_reg);
    assign t2_s   = AW'(t2_reg);
    assign av_s   = $signed({{(AW-DW){1'b0}}, quo_reg});
    assign neg_t1 = -t1_s;
    assign oor_c  = t2_reg[IB-1] || (t1_s >= av_s) || (quo_reg == '0);
    assign s1_c   = t1_reg[IB-1] ? '0 : t1_s[CW-1:0];
    assign s2_c   = (t2_s >= av_s) ? (quo_reg - CW'(1)) : t2_s[CW-1:0];
    assign dst_c  = t1_reg[IB-1] ? neg_t1[mmpag_pkg::OFS_W-1:0] : '0;

    // ---------------- offset accumulator ----------------
    logic [LW-1:0]                 j_reg, acc_idx;
    logic [mmpag_pkg::OFF_W-1:0]   off_reg;
    mmpag_pkg::pow3_t              acc_term;

    assign acc_idx  = lvl_a_reg - j_reg;
    assign acc_term = (j_reg <= lvl_a_reg) ? mmpag_pkg::POW3[acc_idx] : '0;

    // ---------------- status to controller ----------------
    assign sts.early    = nr_reg || br_reg || zf_reg;
    assign sts.div_done = (div_cnt_reg == '0) && scan_done_reg;
    assign sts.acc_done = oor_reg || raw_reg || !pot_reg || (j_reg >= lvl_k_reg);

    // ---------------- result assembly ----------------
    logic [LW-1:0]                  pk_idx;
    mmpag_pkg::pow3_t               pk;
    logic [mmpag_pkg::SUM_W-1:0]    mn_full, mx_full;
    logic [mmpag_pkg::COPY_W-1:0]   cnt_c;
    mmpag_pkg::status_t             res_status;
    logic                           res_pyr;
    logic [mmpag_pkg::ADDR_W-1:0]   res_mn, res_mx;
    logic [mmpag_pkg::COPY_W-1:0]   res_cnt;
    logic [mmpag_pkg::OFS_W-1:0]    res_dst;
    logic [mmpag_pkg::WLEN_W-1:0]   res_wlen;

    assign pk_idx  = lvl_a_reg - lvl_k_reg;
    assign pk      = (lvl_k_reg <= lvl_a_reg) ? mmpag_pkg::POW3[pk_idx] : '0;
    assign mn_full = mmpag_pkg::SUM_W'(s1_reg) + mmpag_pkg::SUM_W'(off_reg);
    assign mx_full = mn_full + mmpag_pkg::SUM_W'(pk);
    assign cnt_c   = mmpag_pkg::COPY_W'(s2_reg) - mmpag_pkg::COPY_W'(s1_reg)
                   + mmpag_pkg::COPY_W'(1);

    always_comb begin
        res_status = mmpag_pkg::ST_SERVED;
        res_pyr    = 1'b0;
        res_mn     = '0;
        res_mx     = '0;
        res_cnt    = '0;
        res_dst    = '0;
        res_wlen   = '0;
        priority if (nr_reg) begin
            res_status = mmpag_pkg::ST_NOT_READY;
        end else if (br_reg) begin
            res_status = mmpag_pkg::ST_BAD_RANGE;
        end else if (zf_reg) begin
            res_status = mmpag_pkg::ST_BAD_FACTOR;
        end else if (oor_reg) begin
            res_status = mmpag_pkg::ST_OUT_OF_RANGE;
            res_wlen   = wlen_reg;
        end else if (raw_reg) begin
            res_mn   = mmpag_pkg::ADDR_W'(s1_reg);
            res_mx   = mmpag_pkg::ADDR_W'(s1_reg);
            res_cnt  = cnt_c;
            res_dst  = dst_reg;
            res_wlen = wlen_reg;
        end else if (!pot_reg) begin
            res_status = mmpag_pkg::ST_BAD_FACTOR;
        end else begin
            res_pyr  = 1'b1;
            res_mn   = mn_full[mmpag_pkg::ADDR_W-1:0];
            res_mx   = mx_full[mmpag_pkg::ADDR_W-1:0];
            res_cnt  = cnt_c;
            res_dst  = dst_reg;
            res_wlen = wlen_reg;
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg   <= '0;
            li_reg        <= '0;
            scan_done_reg <= 1'b0;
            a_found_reg   <= 1'b0;
            pot_reg       <= 1'b0;
            nr_reg        <= 1'b0;
            br_reg        <= 1'b0;
            zf_reg        <= 1'b0;
            raw_reg       <= 1'b0;
            oor_reg       <= 1'b0;
            j_reg         <= '0;
            lvl_k_reg     <= '0;
        end else begin
            if (cmd.load) begin
                nr_reg        <= !cfg_pyramid_ready;
                br_reg        <= (s_last_index < s_first_index);
                zf_reg        <= (s_decim_factor == '0);
                raw_reg       <= (s_decim_factor == DW'(1));
                div_cnt_reg   <= mmpag_pkg::DIV_CNT_W'(DW);
                li_reg        <= '0;
                scan_done_reg <= 1'b0;
                a_found_reg   <= 1'b0;
                pot_reg       <= 1'b0;
                lvl_k_reg     <= '0;
                oor_reg       <= 1'b0;
            end
            if (cmd.div_step) begin
                if (div_cnt_reg != '0) begin
                    div_cnt_reg <= div_cnt_reg - mmpag_pkg::DIV_CNT_W'(1);
                end
                if (!scan_done_reg) begin
                    if (!a_found_reg && ((p_cmp >= n_cmp) || li_at_max)) begin
                        a_found_reg <= 1'b1;
                    end
                    if (p_cmp == d_cmp) begin
                        pot_reg   <= 1'b1;
                        lvl_k_reg <= li_reg;
                    end
                    if (li_at_max) begin
                        scan_done_reg <= 1'b1;
                    end else begin
                        li_reg <= li_reg + LW'(1);
                    end
                end
            end
            if (cmd.range) begin
                oor_reg <= oor_c;
                j_reg   <= LW'(1);
            end
            if (cmd.acc_step) begin
                j_reg <= j_reg + LW'(1);
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            t1_reg   <= s_first_index;
            t2_reg   <= s_last_index;
            ds_reg   <= s_decim_factor;
            wlen_reg <= wlen_c;
            rem_reg  <= '0;
            quo_reg  <= cfg_sample_count;
        end
        if (cmd.div_step) begin
            if (div_cnt_reg != '0) begin
                if (!div_trial[DW+1]) begin
                    rem_reg <= div_trial[DW-1:0];
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[DW-2:0], quo_reg[DW-1]};
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
            end
            if (!scan_done_reg && !a_found_reg && ((p_cmp >= n_cmp) || li_at_max)) begin
                lvl_a_reg <= li_reg;
            end
        end
        if (cmd.range) begin
            s1_reg  <= s1_c;
            s2_reg  <= s2_c;
            dst_reg <= dst_c;
            off_reg <= '0;
        end
        if (cmd.acc_step) begin
            off_reg <= off_reg + {acc_term, 1'b0};
        end
        if (cmd.out_load) begin
            m_status        <= res_status;
            m_from_pyramid  <= res_pyr;
            m_min_start     <= res_mn;
            m_max_start     <= res_mx;
            m_copy_count    <= res_cnt;
            m_dest_offset   <= res_dst;
            m_window_length <= res_wlen;
        end
    end

endmodule

FILE: rtl/minmax_pyramid_address_gen.sv
// ----------------------------------------------------------------------------
// minmax_pyramid_address_gen
// Read addressing for a base-3 min/max pyramid over a sampled time series.
// ----------------------------------------------------------------------------
// Usage:
//   Config port (cfg_wr_en/cfg_index/cfg_wdata) writes pyramid_ready (0) and
//   sample_count (1); write only while the block is idle.
//   Input channel s_*: one window request (first, last, decim_factor) per
//   transfer. Output channel m_*: exactly one result per request, in order.
//   Not ready, bad range and zero factor go straight to the result. The
//   32-step restoring divider (sample_count / decim_factor) sets the
//   length of the divide phase; the level scan runs beside it, and for
//   factor 3^k the offset accumulator adds k - 1 pyramid levels, one per
//   cycle. One request in flight at a time (s_ready high only while idle).
//   The result register frees the sequencer, so the next request runs while
//   a result waits; a second finished result holds until m_ready is seen.
//   Reset (aresetn low, synchronous) clears both config registers to 0,
//   the sequencer and m_valid.
// ----------------------------------------------------------------------------
`include "minmax_pyramid_address_gen_macros.svh"

module minmax_pyramid_address_gen (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // configuration
    input  logic                                      cfg_wr_en,
    input  logic [mmpag_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [mmpag_pkg::CFG_DATA_W-1:0]          cfg_wdata,
    // request channel
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic signed [mmpag_pkg::INDEX_BITS-1:0]   s_first_index,
    input  logic signed [mmpag_pkg::INDEX_BITS-1:0]   s_last_index,
    input  logic [mmpag_pkg::DS_W-1:0]                s_decim_factor,
    // result channel
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic [mmpag_pkg::ST_W-1:0]                m_status,
    output logic                                      m_from_pyramid,
    output logic [mmpag_pkg::ADDR_W-1:0]              m_min_start,
    output logic [mmpag_pkg::ADDR_W-1:0]              m_max_start,
    output logic [mmpag_pkg::COPY_W-1:0]              m_copy_count,
    output logic [mmpag_pkg::OFS_W-1:0]               m_dest_offset,
    output logic [mmpag_pkg::WLEN_W-1:0]              m_window_length
);

    // Config registers
    logic                           pyramid_ready_reg;
    logic [mmpag_pkg::CNT_W-1:0]    sample_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pyramid_ready_reg <= 1'b0;
            sample_count_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (mmpag_pkg::cfg_reg_t'(cfg_index))
                mmpag_pkg::REG_PYRAMID_READY: pyramid_ready_reg <= cfg_wdata[0];
                mmpag_pkg::REG_SAMPLE_COUNT:
                    sample_count_reg <= cfg_wdata[mmpag_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mmpag_pkg::cmd_t cmd;
    mmpag_pkg::sts_t sts;

    // Sequencer
    mmpag_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Arithmetic and result register
    mmpag_dpath u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_pyramid_ready (pyramid_ready_reg),
        .cfg_sample_count  (sample_count_reg),
        .s_first_index     (s_first_index),
        .s_last_index      (s_last_index),
        .s_decim_factor    (s_decim_factor),
        .m_status          (m_status),
        .m_from_pyramid    (m_from_pyramid),
        .m_min_start       (m_min_start),
        .m_max_start       (m_max_start),
        .m_copy_count      (m_copy_count),
        .m_dest_offset     (m_dest_offset),
        .m_window_length   (m_window_length)
    );

    // Result decode for the checks
    logic out_pyr, out_served, out_raw, out_error, out_zero;

    assign out_pyr    = m_valid && m_from_pyramid;
    assign out_served = m_valid && (m_status == mmpag_pkg::ST_SERVED);
    assign out_raw    = out_served && !m_from_pyramid;
    assign out_error  = m_valid && (m_status != mmpag_pkg::ST_SERVED)
                     && (m_status != mmpag_pkg::ST_OUT_OF_RANGE);
    assign out_zero   = (m_window_length == '0) && (m_copy_count == '0);

    // Checks
    `MMPAG_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "s_ready after transfer")
    `MMPAG_ASSERT_NOW(a_pyramid_served, out_pyr, out_served, "pyramid read not served")
    `MMPAG_ASSERT_NOW(a_raw_min_eq_max, out_raw, m_min_start == m_max_start, "raw min != max")
    `MMPAG_ASSERT_NOW(a_error_zero_fields, out_error, out_zero, "nonzero fields on error")

endmodule

FILE: test/pyramid_read_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pyramid_read_check
// Watches the config port and both channels of the pyramid address
// generator. Predicts each read plan and compares it field by field.
// ----------------------------------------------------------------------------
module pyramid_read_check (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      cfg_wr_en,
    input  logic [mmpag_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [mmpag_pkg::CFG_DATA_W-1:0]          cfg_wdata,
    input  logic                                      s_valid,
    input  logic                                      s_ready,
    input  logic signed [mmpag_pkg::INDEX_BITS-1:0]   s_first_index,
    input  logic signed [mmpag_pkg::INDEX_BITS-1:0]   s_last_index,
    input  logic [mmpag_pkg::DS_W-1:0]                s_decim_factor,
    input  logic                                      m_valid,
    input  logic                                      m_ready,
    input  logic [mmpag_pkg::ST_W-1:0]                m_status,
    input  logic                                      m_from_pyramid,
    input  logic [mmpag_pkg::ADDR_W-1:0]              m_min_start,
    input  logic [mmpag_pkg::ADDR_W-1:0]              m_max_start,
    input  logic [mmpag_pkg::COPY_W-1:0]              m_copy_count,
    input  logic [mmpag_pkg::OFS_W-1:0]               m_dest_offset,
    input  logic [mmpag_pkg::WLEN_W-1:0]              m_window_length,
    output int                                        mismatches,
    output int                                        plans_pending
);
    import mmpag_pkg::*;

    typedef struct {
        status_t            status;
        logic               from_pyramid;
        logic [ADDR_W-1:0]  min_start;
        logic [ADDR_W-1:0]  max_start;
        logic [COPY_W-1:0]  copy_count;
        logic [OFS_W-1:0]   dest_offset;
        logic [WLEN_W-1:0]  window_length;
    } read_plan_t;

    localparam longint unsigned WLEN_MAX = (64'd1 << WLEN_W) - 1;

    logic                  ready_reg;
    logic [CFG_DATA_W-1:0] count_reg;
    read_plan_t            plans_due[$];

    task automatic report(input string what);
        $display("%0t: %s", $time, what);
        mismatches++;
    endtask

    // Where in the pyramid (or the raw series) a window is read from.
    function automatic read_plan_t plan_read(input logic signed [INDEX_BITS-1:0] first,
                                             input logic signed [INDEX_BITS-1:0] last,
                                             input logic [DS_W-1:0] ds);
        read_plan_t      p;
        longint          t1, t2, avail, s1, s2;
        longint unsigned span, pw, base, ofs, f;
        bit              is_pow3;
        p.status        = ST_SERVED;
        p.from_pyramid  = 1'b0;
        p.min_start     = '0;
        p.max_start     = '0;
        p.copy_count    = '0;
        p.dest_offset   = '0;
        p.window_length = '0;
        t1 = first;
        t2 = last;
        if (!ready_reg) begin
            p.status = ST_NOT_READY;
        end else if (t2 < t1) begin
            p.status = ST_BAD_RANGE;
        end else if (ds == 0) begin
            p.status = ST_BAD_FACTOR;
        end else begin
            avail = {32'd0, count_reg / ds};
            span  = t2 - t1 + 1;
            p.window_length = (span > WLEN_MAX) ? WLEN_MAX[WLEN_W-1:0] : span[WLEN_W-1:0];
            if (t2 < 0 || t1 >= avail || avail == 0) begin
                p.status        = ST_OUT_OF_RANGE;
            end else begin
                s1 = (t1 < 0) ? 0 : t1;
                s2 = (t2 >= avail) ? avail - 1 : t2;
                p.copy_count  = COPY_W'(s2 - s1 + 1);
                p.dest_offset = (t1 < 0) ? OFS_W'(-t1) : '0;
                pw = 1;
                is_pow3 = 1'b0;
                for (int i = 0; i <= MAX_LEVELS; i++) begin
                    if (pw == ds) is_pow3 = 1'b1;
                    pw = pw * 3;
                end
                if (ds == 1) begin
                    p.min_start = ADDR_W'(s1);
                    p.max_start = ADDR_W'(s1);
                end else if (!is_pow3) begin
                    p.status        = ST_BAD_FACTOR;
                    p.window_length = '0;
                    p.copy_count    = '0;
                    p.dest_offset   = '0;
                end else begin
                    // base length, then skip the levels below the factor
                    base = 1;
                    for (int i = 0; i < MAX_LEVELS && base < count_reg; i++)
                        base = base * 3;
                    ofs = 0;
                    f   = 3;
                    for (int i = 0; i < MAX_LEVELS && f < ds; i++) begin
                        ofs = ofs + 2 * (base / f);
                        f   = f * 3;
                    end
                    p.from_pyramid = 1'b1;
                    p.min_start    = ADDR_W'(s1 + ofs);
                    p.max_start    = ADDR_W'(s1 + ofs + base / ds);
                end
            end
        end
        return p;
    endfunction

    task automatic compare_plan(input read_plan_t want);
        if (m_status !== want.status)
            report($sformatf("status %0d, expected %0d", m_status, want.status));
        if (m_from_pyramid !== want.from_pyramid)
            report($sformatf("from_pyramid %0b, expected %0b",
                             m_from_pyramid, want.from_pyramid));
        if (m_min_start !== want.min_start)
            report($sformatf("min_start 0x%0h, expected 0x%0h", m_min_start, want.min_start));
        if (m_max_start !== want.max_start)
            report($sformatf("max_start 0x%0h, expected 0x%0h", m_max_start, want.max_start));
        if (m_copy_count !== want.copy_count)
            report($sformatf("copy_count 0x%0h, expected 0x%0h",
                             m_copy_count, want.copy_count));
        if (m_dest_offset !== want.dest_offset)
            report($sformatf("dest_offset 0x%0h, expected 0x%0h",
                             m_dest_offset, want.dest_offset));
        if (m_window_length !== want.window_length)
            report($sformatf("window_length 0x%0h, expected 0x%0h",
                             m_window_length, want.window_length));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg = 1'b0;
            count_reg = '0;
            plans_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (plans_due.size() == 0)
                    report($sformatf("result transfer with no request pending, status %0d",
                                     m_status));
                else
                    compare_plan(plans_due.pop_front());
            end
            if (s_valid && s_ready)
                plans_due.push_back(plan_read(s_first_index, s_last_index, s_decim_factor));
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    REG_PYRAMID_READY: ready_reg = cfg_wdata[0];
                    REG_SAMPLE_COUNT:  count_reg = cfg_wdata;
                    default: ;
                endcase
            end
        end
        plans_pending = plans_due.size();
    end

endmodule

FILE: test/minmax_pyramid_address_gen_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minmax_pyramid_address_gen_test
// Drives window requests and config settings into the pyramid address
// generator; pyramid_read_check predicts and compares every result.
// ----------------------------------------------------------------------------
module minmax_pyramid_address_gen_test;
    import mmpag_pkg::*;

    localparam int                 LONG_HOLD   = 250;  // receiver back-pressure stretch
    localparam int                 TAIL_CYCLES = 64;   // latency margin at the end
    localparam longint             IDX_MAX     = (longint'(1) <<< (INDEX_BITS - 1)) - 1;
    localparam longint             IDX_MIN     = -IDX_MAX - 1;
    localparam logic [DS_W-1:0]    POW3_20     = 32'd3486784401;  // largest 32-bit 3^k

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_wdata;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [INDEX_BITS-1:0]  s_first_index;
    logic signed [INDEX_BITS-1:0]  s_last_index;
    logic [DS_W-1:0]               s_decim_factor;
    logic                          m_valid;
    logic                          m_ready;
    logic [ST_W-1:0]               m_status;
    logic                          m_from_pyramid;
    logic [ADDR_W-1:0]             m_min_start;
    logic [ADDR_W-1:0]             m_max_start;
    logic [COPY_W-1:0]             m_copy_count;
    logic [OFS_W-1:0]              m_dest_offset;
    logic [WLEN_W-1:0]             m_window_length;

    int                            mismatches;
    int                            plans_pending;
    int                            results_seen;
    bit                            steady;     // both sides run without idling
    logic [CFG_DATA_W-1:0]         cur_count;  // sample_count as last written

    minmax_pyramid_address_gen dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_first_index   (s_first_index),
        .s_last_index    (s_last_index),
        .s_decim_factor  (s_decim_factor),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_from_pyramid  (m_from_pyramid),
        .m_min_start     (m_min_start),
        .m_max_start     (m_max_start),
        .m_copy_count    (m_copy_count),
        .m_dest_offset   (m_dest_offset),
        .m_window_length (m_window_length)
    );

    pyramid_read_check read_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_first_index   (s_first_index),
        .s_last_index    (s_last_index),
        .s_decim_factor  (s_decim_factor),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_from_pyramid  (m_from_pyramid),
        .m_min_start     (m_min_start),
        .m_max_start     (m_max_start),
        .m_copy_count    (m_copy_count),
        .m_dest_offset   (m_dest_offset),
        .m_window_length (m_window_length),
        .mismatches      (mismatches),
        .plans_pending   (plans_pending)
    );

    // 12 ns clock
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Hard stop. Worst honest run is roughly 1400 requests x (long sender gap
    // + latency + long receiver gap) plus the back-pressure holds; this allows
    // several times that.
    initial begin
        #20_000_000;
        $display("minmax_pyramid_address_gen_test: done, errors");
        $finish;
    end

    // Mostly short gaps, a few long ones; none during a steady phase.
    function automatic int idle_cycles();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random 40-bit index, sign-extended.
    function automatic longint any_index();
        logic [63:0]                  raw;
        logic signed [INDEX_BITS-1:0] v;
        raw = {$urandom, $urandom};
        v   = raw[INDEX_BITS-1:0];
        return v;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) results_seen <= results_seen + 1;
    end

    // Result side. Random ready gaps, plus a long hold-off after 150 and after
    // 900 results so the output slot fills and s_ready drops while the sender
    // keeps offering.
    initial begin : result_sink
        int quiet;
        int next_hold;
        quiet     = 0;
        next_hold = 150;
        m_ready   = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (quiet > 0) begin
                m_ready <= 1'b0;
                quiet--;
            end else if (results_seen >= next_hold) begin
                m_ready <= 1'b0;
                quiet     = LONG_HOLD - 1;
                next_hold = next_hold + 750;
            end else begin
                m_ready <= 1'b1;
                quiet = idle_cycles();
            end
        end
    end

    // One request transfer. With no gap, valid stays high and only the
    // payload moves on to the next request.
    task automatic offer(input longint first, input longint last,
                         input logic [DS_W-1:0] factor);
        int gap;
        gap = idle_cycles();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_first_index  <= first[INDEX_BITS-1:0];
        s_last_index   <= last[INDEX_BITS-1:0];
        s_decim_factor <= factor;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Sender pauses until every result has been returned; block is idle then.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (plans_pending != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input bit ready, input logic [CFG_DATA_W-1:0] count);
        drain();
        write_reg(REG_PYRAMID_READY, CFG_DATA_W'(ready));
        write_reg(REG_SAMPLE_COUNT, count);
        cur_count = count;
    endtask

    // Mostly well-formed requests: a power-of-3 factor that leaves columns at
    // the current sample_count (if nonzero), and a window near or across the valid range.
    // The rest is zero or junk factors, raw random indexes, reversed windows.
    task automatic offer_random();
        longint unsigned ds, pw;
        longint          avail, first, last, len;
        int              kmax, r, r2;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            kmax = 0;
            pw   = 3;
            while (kmax < 20 && pw <= cur_count) begin
                kmax++;
                pw = pw * 3;
            end
            ds = 1;
            repeat ($urandom_range(0, kmax)) ds = ds * 3;
        end else if (r < 80) begin
            ds = 0;
        end else if (r < 88) begin
            ds = $urandom_range(2, 30);
        end else begin
            ds = $urandom;
        end
        avail = (ds == 0) ? 0 : longint'(cur_count / ds);

        r = $urandom_range(0, 99);
        if (r < 12) begin
            first = any_index();
            last  = any_index();
        end else begin
            r2 = $urandom_range(0, 99);
            if (avail == 0)
                first = longint'($urandom_range(0, 4)) - 2;
            else if (r2 < 20)
                first = -longint'($urandom_range(1, 40));
            else if (r2 < 35)
                first = avail - longint'($urandom_range(0, 3));
            else
                first = longint'($urandom) % avail;
            r2 = $urandom_range(0, 99);
            if (r2 < 65)
                len = $urandom_range(0, 24);
            else if (r2 < 90)
                len = longint'($urandom) % (avail + 2);
            else
                len = longint'({$urandom, $urandom} >> 25);
            last = first + len;
            if (last > IDX_MAX) last = IDX_MAX;
            if (r >= 95) last = first - longint'($urandom_range(1, 9));
        end
        offer(first, last, ds[DS_W-1:0]);
    endtask

    task automatic run_phase(input bit ready, input logic [CFG_DATA_W-1:0] count,
                             input int requests, input bit no_idle);
        configure(ready, count);
        steady = no_idle;
        repeat (requests) offer_random();
        steady = 1'b0;
    endtask

    initial begin : stimulus
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_PYRAMID_READY;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_first_index  = '0;
        s_last_index   = '0;
        s_decim_factor = '0;
        steady         = 1'b0;
        cur_count      = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // straight out of reset: not ready wins over everything
        offer(0, 10, 1);
        offer(5, 1, 0);

        configure(1'b1, 1000);
        offer(10, 9, 3);                  // reversed window
        offer(0, 5, 0);                   // zero factor
        offer(-20, -1, 1);                // window ends before column 0
        offer(1000, 1005, 1);             // starts past the data
        offer(0, 5, 2187);                // factor leaves no columns
        offer(600, 700, 2);               // outside the data, so bad factor not flagged
        offer(10, 20, 2);                 // bad factor
        offer(-5, 10, 1);                 // raw read, data lands at offset 5
        offer(990, 1200, 1);              // raw read clipped at the end
        offer(-3, 400, 3);                // first level, clipped on both sides
        offer(0, 0, 729);                 // single column at 3^6
        offer(IDX_MIN, IDX_MAX, 1);       // widest window, length saturates
        offer(IDX_MAX, IDX_MAX, 9);
        offer(IDX_MIN, IDX_MIN + 1, 1);

        configure(1'b1, 32'hFFFF_FFFF);
        offer(0, 0, POW3_20);             // level 3^20, the highest a 32-bit factor reaches
        offer(0, 2, POW3_20 - 1);
        offer(-1, 0, 32'hFFFF_FFFF);
        offer(64'hFFFF_FFF0, IDX_MAX, 1); // far end of the raw series
        offer(100, 200, 32'h8000_0000);

        configure(1'b1, 1);
        offer(0, 0, 1);
        offer(0, 0, 3);

        run_phase(1'b1, $urandom_range(2, 3000), 300, 1'b0);
        run_phase(1'b1, 32'hFFFF_FFFF, 280, 1'b0);
        run_phase(1'b0, $urandom, 60, 1'b0);
        run_phase(1'b1, $urandom, 300, 1'b0);
        run_phase(1'b1, 1, 100, 1'b1);
        run_phase(1'b1, 0, 60, 1'b0);
        run_phase(1'b1, $urandom_range(59049, 1000000), 280, 1'b0);

        drain();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatches == 0 && plans_pending == 0)
            $display("minmax_pyramid_address_gen_test: done, clean");
        else
            $display("minmax_pyramid_address_gen_test: done, errors");
        $finish;
    end

endmodule
